>>> rtl/pfd_pkg.sv
// Shared types and constants for the Playfair digraph encryption unit.
// Used by pfd_pair_cipher and playfair_digraph_encrypt_unit; no dependencies.
package pfd_pkg;

    localparam int GRID_SIDE = 5;
    localparam int CODE_W    = 5;
    localparam int IDX_W     = 3;
    localparam int ROW_W     = GRID_SIDE * CODE_W;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [CODE_W-1:0] CODE_I = 5'd8;
    localparam logic [CODE_W-1:0] CODE_J = 5'd9;
    localparam logic [CODE_W-1:0] CODE_X = 5'd23;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_0 = 3'd0,
        REG_ROW_1 = 3'd1,
        REG_ROW_2 = 3'd2,
        REG_ROW_3 = 3'd3,
        REG_ROW_4 = 3'd4
    } reg_index_t;

    typedef logic [GRID_SIDE-1:0][ROW_W-1:0] square_t;

    localparam square_t SQUARE_RESET = {
        25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
    };

    typedef struct packed {
        logic [CODE_W-1:0] letter;
        logic              last;
    } plain_t;

    typedef struct packed {
        logic [CODE_W-1:0] cipher_first;
        logic [CODE_W-1:0] cipher_second;
    } cipher_t;

    typedef struct packed {
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
    } pair_t;

endpackage

>>> rtl/pfd_pair_cipher.sv
// Combinational Playfair encryption of one letter pair against the key square.
// Depends on pfd_pkg.
module pfd_pair_cipher
    import pfd_pkg::*;
(
    input  square_t square,
    input  pair_t   pair,
    output cipher_t cipher
);

    logic [IDX_W-1:0]  row_a;
    logic [IDX_W-1:0]  col_a;
    logic [IDX_W-1:0]  row_b;
    logic [IDX_W-1:0]  col_b;
    logic [IDX_W-1:0]  row_a_sel;
    logic [IDX_W-1:0]  col_a_sel;
    logic [IDX_W-1:0]  row_b_sel;
    logic [IDX_W-1:0]  col_b_sel;
    logic [CODE_W-1:0] code_a;
    logic [CODE_W-1:0] code_b;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(GRID_SIDE - 1))
            res = '0;
        else
            res = idx + 1'b1;
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] cell_code(
        input square_t          sq,
        input logic [IDX_W-1:0] r,
        input logic [IDX_W-1:0] c
    );
        logic [CODE_W-1:0] res;
        res = '0;
        for (int i = 0; i < GRID_SIDE; i++)
        begin
            for (int k = 0; k < GRID_SIDE; k++)
            begin
                if (r == IDX_W'(i) && c == IDX_W'(k))
                    res = sq[i][k*CODE_W +: CODE_W];
            end
        end
        return res;
    endfunction

    always_comb
    begin
        code_a = (pair.first == CODE_J) ? CODE_I : pair.first;
        code_b = (pair.second == CODE_J) ? CODE_I : pair.second;
        row_a  = '0;
        col_a  = '0;
        row_b  = '0;
        col_b  = '0;
        // scan backward so the first match in row-major order wins
        for (int n = CELLS - 1; n >= 0; n--)
        begin
            if (square[n / GRID_SIDE][(n % GRID_SIDE)*CODE_W +: CODE_W] == code_a)
            begin
                row_a = IDX_W'(n / GRID_SIDE);
                col_a = IDX_W'(n % GRID_SIDE);
            end
            if (square[n / GRID_SIDE][(n % GRID_SIDE)*CODE_W +: CODE_W] == code_b)
            begin
                row_b = IDX_W'(n / GRID_SIDE);
                col_b = IDX_W'(n % GRID_SIDE);
            end
        end

        if (row_a == row_b)
        begin
            row_a_sel = row_a;
            row_b_sel = row_b;
            col_a_sel = wrap_inc(col_a);
            col_b_sel = wrap_inc(col_b);
        end
        else if (col_a == col_b)
        begin
            row_a_sel = wrap_inc(row_a);
            row_b_sel = wrap_inc(row_b);
            col_a_sel = col_a;
            col_b_sel = col_b;
        end
        else
        begin
            row_a_sel = row_a;
            row_b_sel = row_b;
            col_a_sel = col_b;
            col_b_sel = col_a;
        end

        cipher.cipher_first  = cell_code(square, row_a_sel, col_a_sel);
        cipher.cipher_second = cell_code(square, row_b_sel, col_b_sel);
    end

endmodule

>>> rtl/playfair_digraph_encrypt_unit.sv
// Playfair digraph encryption unit: pairs plaintext letters and encrypts each pair.
// A pair is registered in the pair register, then its result in the result register.
// Throughput: one letter per cycle while plain_stall is low; a pair register and a
// result register are separated, so a letter is taken while a result waits unless
// a pair is also pending. Reset clears the hold, both valid flags and loads the
// alphabetic key square. Depends on pfd_pkg, pfd_pair_cipher.
module playfair_digraph_encrypt_unit
    import pfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              plain_valid,
    output logic              plain_stall,
    input  plain_t            plain_data,
    output logic              cipher_valid,
    input  logic              cipher_stall,
    output cipher_t           cipher_data
);

    square_t           square_reg;
    logic              holding_reg;
    logic [CODE_W-1:0] held_reg;
    logic              pair_valid_reg;
    pair_t             pair_reg;
    logic              out_valid_reg;
    cipher_t           out_reg;

    square_t           square_next;
    logic              holding_next;
    logic [CODE_W-1:0] held_next;
    logic              pair_valid_next;
    pair_t             pair_next;
    logic              out_valid_next;
    cipher_t           out_next;

    logic              wr_en;
    logic [IDX_W-1:0]  reg_idx;
    logic              accept;
    logic              make_pair;
    logic              s2_load;
    cipher_t           cipher_comb;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        square_next = square_reg;
        if (wr_en)
        begin
            case (reg_index_t'(reg_idx))
                REG_ROW_0: square_next[0] = pwdata[ROW_W-1:0];
                REG_ROW_1: square_next[1] = pwdata[ROW_W-1:0];
                REG_ROW_2: square_next[2] = pwdata[ROW_W-1:0];
                REG_ROW_3: square_next[3] = pwdata[ROW_W-1:0];
                REG_ROW_4: square_next[4] = pwdata[ROW_W-1:0];
                default:   square_next = square_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(reg_idx))
            REG_ROW_0: prdata = DATA_W'(square_reg[0]);
            REG_ROW_1: prdata = DATA_W'(square_reg[1]);
            REG_ROW_2: prdata = DATA_W'(square_reg[2]);
            REG_ROW_3: prdata = DATA_W'(square_reg[3]);
            REG_ROW_4: prdata = DATA_W'(square_reg[4]);
            default:   prdata = '0;
        endcase
    end

    assign s2_load     = pair_valid_reg && (!out_valid_reg || !cipher_stall);
    assign plain_stall = pair_valid_reg && !s2_load;
    assign accept      = plain_valid && !plain_stall;
    assign make_pair   = accept && (holding_reg || plain_data.last);

    always_comb
    begin
        holding_next = holding_reg;
        held_next    = held_reg;
        pair_next    = pair_reg;
        if (accept)
        begin
            if (holding_reg)
            begin
                holding_next     = 1'b0;
                pair_next.first  = held_reg;
                pair_next.second = plain_data.letter;
            end
            else if (plain_data.last)
            begin
                pair_next.first  = plain_data.letter;
                pair_next.second = CODE_X;
            end
            else
            begin
                holding_next = 1'b1;
                held_next    = plain_data.letter;
            end
        end

        if (make_pair)
            pair_valid_next = 1'b1;
        else if (s2_load)
            pair_valid_next = 1'b0;
        else
            pair_valid_next = pair_valid_reg;

        if (s2_load)
        begin
            out_valid_next = 1'b1;
            out_next       = cipher_comb;
        end
        else
        begin
            out_valid_next = out_valid_reg && cipher_stall;
            out_next       = out_reg;
        end
    end

    pfd_pair_cipher u_cipher (
        .square (square_reg),
        .pair   (pair_reg),
        .cipher (cipher_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg     <= SQUARE_RESET;
            holding_reg    <= 1'b0;
            held_reg       <= '0;
            pair_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            square_reg     <= square_next;
            holding_reg    <= holding_next;
            held_reg       <= held_next;
            pair_valid_reg <= pair_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
        out_reg  <= out_next;
    end

    assign cipher_valid = out_valid_reg;
    assign cipher_data  = out_reg;

    a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid_reg && !s2_load |=> pair_valid_reg)
        else $error("pending pair dropped");

    a_hold_open: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !holding_reg && !plain_data.last |=> holding_reg)
        else $error("first letter of pair not held");

    a_hold_close: assert property (@(posedge clk) disable iff (!rst_n)
        make_pair |=> !holding_reg && pair_valid_reg)
        else $error("pair not formed");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> out_valid_reg)
        else $error("result lost");

endmodule
